[rtl/isr_pkg.sv]
`default_nettype none

package isr_pkg;

   // radicand width and the number of two-bit digit steps it takes
   localparam int INPUT_BITS = 31;
   localparam int STEPS      = (INPUT_BITS + 1) / 2;
   localparam int RAD_W      = 2 * STEPS;
   localparam int REM_W      = STEPS + 3;
   localparam int ROOT_W     = 16;
   localparam int Q_EXT_W    = STEPS + ROOT_W;

   typedef logic [INPUT_BITS-1:0] radicand_type;
   typedef logic [ROOT_W-1:0]     root_type;

   typedef struct packed {
      logic [RAD_W-1:0] rad;
      logic [REM_W-1:0] rem;
      logic [STEPS-1:0] q;
   } isr_data_type;

   // low root bits, zero extended when the root is narrower than the field
   function automatic root_type root_of(input logic [STEPS-1:0] q);
      logic [Q_EXT_W-1:0] ext;
      ext = Q_EXT_W'(q);
      return ext[ROOT_W-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/isr_cell.sv]
`default_nettype none

module isr_cell (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   up_valid,
   output logic                  up_ready,
   input  isr_pkg::isr_data_type up_data,
   output logic                  down_valid,
   input  wire                   down_ready,
   output isr_pkg::isr_data_type down_data
);
   import isr_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   isr_data_type data_ff;
   isr_data_type data_in;
   logic         load;
   logic [REM_W-1:0] part;
   logic [REM_W-1:0] trial;
   logic             take;

   assign load     = !valid_ff || down_ready;
   assign up_ready = load;

   // one root digit: bring down two radicand bits, try appending a one
   always_comb begin
      part  = {up_data.rem[REM_W-3:0], up_data.rad[RAD_W-1 -: 2]};
      trial = REM_W'({up_data.q, 2'b01});
      take  = part >= trial;
      data_in.rad = {up_data.rad[RAD_W-3:0], 2'b00};
      data_in.rem = take ? part - trial : part;
      data_in.q   = (up_data.q << 1) | STEPS'(take);
      valid_in    = load ? up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data  = data_ff;

endmodule

`default_nettype wire

[rtl/integer_square_root.sv]
// structure: one cell per root digit
// throughput: one beat per cycle while the output is not stalled; a stalled output lets empty cells ahead of it fill
// the row of digit cells is the only thing that sets latency and throughput
// reset: synchronous, active high, clears every cell's valid bit; no other state
`default_nettype none

module integer_square_root (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  isr_pkg::radicand_type req_radicand,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output isr_pkg::root_type     rsp_root
);
   import isr_pkg::*;

   // link k feeds cell k; link STEPS is the output of the last cell
   logic         link_valid [STEPS+1];
   logic         link_ready [STEPS+1];
   isr_data_type link_data  [STEPS+1];
   logic [STEPS-1:0] occupied;

   // first cell sees the radicand padded to whole digit pairs, empty remainder and root
   assign link_valid[0]    = req_valid;
   assign req_ready        = link_ready[0];
   assign link_data[0].rad = RAD_W'(req_radicand);
   assign link_data[0].rem = '0;
   assign link_data[0].q   = '0;

   // row of digit cells, most significant digit first
   for (genvar k = 0; k < STEPS; k++) begin : g_cell
      isr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (link_valid[k]),
         .up_ready   (link_ready[k]),
         .up_data    (link_data[k]),
         .down_valid (link_valid[k+1]),
         .down_ready (link_ready[k+1]),
         .down_data  (link_data[k+1])
      );
      assign occupied[k] = link_valid[k+1];
   end

   // the last cell's register is the output register
   assign link_ready[STEPS] = rsp_ready;
   assign rsp_valid         = link_valid[STEPS];
   assign rsp_root          = root_of(link_data[STEPS].q);

   // input stalls only when every cell holds a beat
   a_full_when_stalled : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&occupied))
      else $error("input stalled with an empty cell");

   // input stalls only behind a stalled output
   a_stall_from_output : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled while output drains");

   // a beat taken in with none leaving adds exactly one occupied cell
   a_count_grows : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !(rsp_valid && rsp_ready))
      |=> ($countones(occupied) == $past($countones(occupied)) + 1))
      else $error("beat lost or duplicated in the cell row");

   // a beat leaving with none taken in frees exactly one cell
   a_count_shrinks : assert property (@(posedge clock) disable iff (reset)
      (!(req_valid && req_ready) && rsp_valid && rsp_ready)
      |=> ($countones(occupied) + 1 == $past($countones(occupied))))
      else $error("beat lost or duplicated in the cell row");

endmodule

`default_nettype wire

[sim/integer_square_root_test.sv]
`default_nettype none

module integer_square_root_test;
   import isr_pkg::*;

   // generous bound, far above what the stimulus needs even with heavy idling
   localparam int CYCLE_LIMIT = 400000;
   // pipeline depth is one cell per root digit; the drain tail is longer than that depth
   localparam int TAIL_CYCLES = 4 * STEPS;
   localparam int RANDOM_PER_PHASE = 320;
   // largest root that a 31-bit radicand can have
   localparam int unsigned MAX_ROOT = 46340;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   radicand_type req_radicand = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   root_type     rsp_root;

   // radicands waiting to be driven, roots waiting to come back
   radicand_type pending_radicands[$];
   root_type     expected_roots[$];

   // idle chances in percent, set per phase by the stimulus block
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;

   int unsigned queued_count = 0;
   int unsigned checked_count = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   bit          req_taken = 1'b0;

   integer_square_root dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_radicand (req_radicand),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_root     (rsp_root)
   );

   always #10 clock = ~clock;

   // floor of the square root, two radicand bits per step
   function automatic root_type floor_sqrt(input radicand_type radicand);
      logic [63:0] rest;
      logic [63:0] acc;
      logic [63:0] one;
      rest = 64'(radicand);
      acc  = '0;
      one  = 64'd1 << 62;
      // start from the highest power of four not above the radicand
      while (one > rest)
         one = one >> 2;
      while (one != 0) begin
         if (rest >= acc + one) begin
            rest = rest - (acc + one);
            acc  = (acc >> 1) + one;
         end else begin
            acc = acc >> 1;
         end
         one = one >> 2;
      end
      // root field keeps only its low bits
      return acc[ROOT_W-1:0];
   endfunction

   // driver: new beats go out on the falling edge, valid holds until taken
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_radicands.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid    <= 1'b1;
            req_radicand <= pending_radicands.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: sample both channels on the rising edge
   always @(posedge clock) begin
      root_type want;
      req_taken = 1'b0;
      if (!reset) begin
         // check the outgoing beat first so a same-edge input cannot satisfy it
         if (rsp_valid && rsp_ready) begin
            if (expected_roots.size() == 0) begin
               $error("root: no result expected, got %0d", rsp_root);
               error_count++;
            end else begin
               want = expected_roots.pop_front();
               checked_count++;
               if (rsp_root !== want) begin
                  $error("root: expected %0d, got %0d", want, rsp_root);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_roots.push_back(floor_sqrt(req_radicand));
            req_taken = 1'b1;
         end
      end
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic add_radicand(input radicand_type value);
      pending_radicands.push_back(value);
      queued_count++;
   endtask

   // random mix: full range, exact squares, both sides of each root step,
   // narrow values so every root width gets exercised
   task automatic add_random(input int unsigned count);
      int unsigned k;
      repeat (count) begin
         k = $urandom_range(MAX_ROOT);
         case ($urandom_range(5))
            0: add_radicand(radicand_type'($urandom()));
            1: add_radicand(radicand_type'(k * k));
            2: add_radicand(radicand_type'(k == 0 ? 0 : k * k - 1));
            3: add_radicand(radicand_type'(k == MAX_ROOT ? k * k : k * k + 2 * k));
            4: add_radicand(radicand_type'($urandom() >> $urandom_range(31, 1)));
            default: add_radicand(radicand_type'($urandom_range(300)));
         endcase
      end
   endtask

   // sender holds off until every beat in flight has come back
   task automatic wait_drained;
      while (checked_count != queued_count)
         @(negedge clock);
   endtask

   task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      add_random(RANDOM_PER_PHASE);
      wait_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero and one, small squares and their neighbors,
      // powers of four, alternating bit patterns, the top of the range
      add_radicand(radicand_type'(0));
      add_radicand(radicand_type'(1));
      add_radicand(radicand_type'(2));
      add_radicand(radicand_type'(3));
      add_radicand(radicand_type'(4));
      add_radicand(radicand_type'(8));
      add_radicand(radicand_type'(9));
      add_radicand(radicand_type'(15));
      add_radicand(radicand_type'(16));
      add_radicand(radicand_type'(255));
      add_radicand(radicand_type'(256));
      add_radicand(radicand_type'(65535));
      add_radicand(radicand_type'(65536));
      add_radicand(radicand_type'(32'h3FFF_FFFF));
      add_radicand(radicand_type'(32'h4000_0000));
      add_radicand(radicand_type'(32'h5555_5555));
      add_radicand(radicand_type'(32'h2AAA_AAAA));
      add_radicand(radicand_type'(MAX_ROOT * MAX_ROOT - 1));
      add_radicand(radicand_type'(MAX_ROOT * MAX_ROOT));
      add_radicand({INPUT_BITS{1'b1}});
      wait_drained();

      // idling phases: none, sender only, receiver only, both
      run_phase(0, 0);
      run_phase(55, 0);
      run_phase(0, 55);
      run_phase(37, 37);

      // let any stray beat surface before the verdict
      recv_stall_pct = 0;
      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);

      if (error_count == 0 && expected_roots.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         if (expected_roots.size() != 0)
            $error("root: %0d results never arrived", expected_roots.size());
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire
